// File: sv/sia_pkg.sv
package sia_pkg;

  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  localparam int NUM_TURNS = 4;

endpackage

// File: sv/sia_ram.sv
module sia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/sia_meets.sv
module sia_meets #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sia_pkg::tag_t     in_ctl,
  input  logic [4*CW-1:0]   s_seg,
  input  logic [4*CW-1:0]   t_seg,
  output sia_pkg::tag_t     out_ctl,
  output logic              hit
);

  localparam int NT = sia_pkg::NUM_TURNS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int VW = 2 * CW + 3;

  function automatic logic signed [DW-1:0] sdiff(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
    sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic box(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                               input logic [CW-1:0] qx, input logic [CW-1:0] qy,
                               input logic [CW-1:0] bx, input logic [CW-1:0] by);
    logic okx;
    logic oky;
    okx = ((qx >= ax) && (qx <= bx)) || ((qx >= bx) && (qx <= ax));
    oky = ((qy >= ay) && (qy <= by)) || ((qy >= by) && (qy <= ay));
    box = okx && oky;
  endfunction

  logic [CW-1:0] sax, say, sbx, sby, tax, tay, tbx, tby;
  logic [CW-1:0] px [NT];
  logic [CW-1:0] py [NT];
  logic [CW-1:0] qx [NT];
  logic [CW-1:0] qy [NT];
  logic [CW-1:0] rx [NT];
  logic [CW-1:0] ry [NT];
  logic [NT-1:0] box_w;

  logic signed [DW-1:0] d1_r [NT];
  logic signed [DW-1:0] d2_r [NT];
  logic signed [DW-1:0] d3_r [NT];
  logic signed [DW-1:0] d4_r [NT];
  logic signed [PW-1:0] m1_r [NT];
  logic signed [PW-1:0] m2_r [NT];
  logic [NT-1:0]        box1_r, box2_r;
  sia_pkg::tag_t        ctl1_r, ctl2_r, ctl3_r;
  logic                 hit_r;

  logic signed [VW-1:0] v [NT];
  logic [1:0]           code [NT];
  logic [NT-1:0]        zero;
  logic                 hit_nxt;

  assign sax = s_seg[4*CW-1 -: CW];
  assign say = s_seg[3*CW-1 -: CW];
  assign sbx = s_seg[2*CW-1 -: CW];
  assign sby = s_seg[CW-1 -: CW];
  assign tax = t_seg[4*CW-1 -: CW];
  assign tay = t_seg[3*CW-1 -: CW];
  assign tbx = t_seg[2*CW-1 -: CW];
  assign tby = t_seg[CW-1 -: CW];

  always_comb begin
    px[0] = sax; py[0] = say; qx[0] = sbx; qy[0] = sby; rx[0] = tax; ry[0] = tay;
    px[1] = sax; py[1] = say; qx[1] = sbx; qy[1] = sby; rx[1] = tbx; ry[1] = tby;
    px[2] = tax; py[2] = tay; qx[2] = tbx; qy[2] = tby; rx[2] = sax; ry[2] = say;
    px[3] = tax; py[3] = tay; qx[3] = tbx; qy[3] = tby; rx[3] = sbx; ry[3] = sby;
    box_w[0] = box(sax, say, tax, tay, sbx, sby);
    box_w[1] = box(sax, say, tbx, tby, sbx, sby);
    box_w[2] = box(tax, tay, sax, say, tbx, tby);
    box_w[3] = box(tax, tay, sbx, sby, tbx, tby);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NT; i++) begin
      d1_r[i] <= sdiff(qy[i], py[i]);
      d2_r[i] <= sdiff(rx[i], qx[i]);
      d3_r[i] <= sdiff(qx[i], px[i]);
      d4_r[i] <= sdiff(ry[i], qy[i]);
      m1_r[i] <= d1_r[i] * d2_r[i];
      m2_r[i] <= d3_r[i] * d4_r[i];
    end
    box1_r <= box_w;
    box2_r <= box1_r;
    hit_r  <= hit_nxt;
  end

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      v[i]    = $signed({m1_r[i][PW-1], m1_r[i]}) - $signed({m2_r[i][PW-1], m2_r[i]});
      zero[i] = (v[i] == '0);
      code[i] = {~zero[i] & v[i][VW-1], ~zero[i] & ~v[i][VW-1]};
    end
    hit_nxt = ((code[0] != code[1]) && (code[2] != code[3])) ||
              |(zero & box2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  assign out_ctl = ctl3_r;
  assign hit     = hit_r;

endmodule

// File: sv/segment_intersection_adjacency_core.sv
// Channel  | Handshake        | Payload
// -------- | ---------------- | ------------------------------------------------
// command  | start, busy      | in_req_type, in_start_x/y, in_end_x/y
// result   | out_valid strobe | out_wire_index, out_row_bits, out_overflow
//
// Add: the core sweeps the segment RAM (one read port, one stored segment per
// cycle) from wire 0 to the new wire into the three-stage orientation
// pipeline behind it; busy holds until the last result leaves that pipeline.
// Clear and overflow requests leave busy low. Reset clears state, not the RAM.
// Results strobe for one cycle; the receiver cannot stall.
module segment_intersection_adjacency_core #(
  parameter int MAX_WIRES  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     in_req_type,
  input  logic [COORD_BITS-1:0]                    in_start_x,
  input  logic [COORD_BITS-1:0]                    in_start_y,
  input  logic [COORD_BITS-1:0]                    in_end_x,
  input  logic [COORD_BITS-1:0]                    in_end_y,
  output logic                                     out_valid,
  output logic [((MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1)-1:0] out_wire_index,
  output logic [MAX_WIRES-1:0]                     out_row_bits,
  output logic                                     out_overflow
);

  localparam int IDX_W = (MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1;
  localparam int CNT_W = $clog2(MAX_WIRES + 1);
  localparam int SEG_W = 4 * COORD_BITS;

  sia_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_k_r, rd_k_nxt;
  logic [IDX_W-1:0] res_k_r, res_k_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [MAX_WIRES-1:0] row_r, row_nxt, row_set;
  logic out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_wire_index_r, out_wire_index_nxt;
  logic [MAX_WIRES-1:0] out_row_bits_r, out_row_bits_nxt;
  logic out_overflow_r, out_overflow_nxt;

  sia_pkg::tag_t issue_ctl, ctl0_r, hit_ctl;
  logic ram_we, ram_re, hit;
  logic [SEG_W-1:0] in_seg, ram_rdata;

  assign in_seg = {in_start_x, in_start_y, in_end_x, in_end_y};
  assign busy   = (state_r != sia_pkg::ST_IDLE);

  sia_ram #(.WIDTH(SEG_W), .DEPTH(MAX_WIRES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_seg),
    .re    (ram_re),
    .raddr (rd_k_r),
    .rdata (ram_rdata)
  );

  sia_meets #(.CW(COORD_BITS)) u_meets (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (ctl0_r),
    .s_seg   (seg_r),
    .t_seg   (ram_rdata),
    .out_ctl (hit_ctl),
    .hit     (hit)
  );

  assign row_set = {{(MAX_WIRES-1){1'b0}}, hit} << res_k_r;

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    idx_nxt            = idx_r;
    rd_k_nxt           = rd_k_r;
    res_k_nxt          = res_k_r;
    seg_nxt            = seg_r;
    row_nxt            = row_r;
    out_valid_nxt      = 1'b0;
    out_wire_index_nxt = out_wire_index_r;
    out_row_bits_nxt   = out_row_bits_r;
    out_overflow_nxt   = out_overflow_r;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    issue_ctl          = '0;
    case (state_r)
      sia_pkg::ST_IDLE: begin
        if (start) begin
          if (!in_req_type) begin
            count_nxt = '0;
          end else if (count_r == CNT_W'(MAX_WIRES)) begin
            out_valid_nxt      = 1'b1;
            out_wire_index_nxt = '0;
            out_row_bits_nxt   = '0;
            out_overflow_nxt   = 1'b1;
          end else begin
            ram_we    = 1'b1;
            seg_nxt   = in_seg;
            idx_nxt   = count_r[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
            rd_k_nxt  = '0;
            res_k_nxt = '0;
            row_nxt   = '0;
            state_nxt = sia_pkg::ST_SWEEP;
          end
        end
      end
      sia_pkg::ST_SWEEP: begin
        ram_re         = 1'b1;
        issue_ctl.vld  = 1'b1;
        issue_ctl.last = (rd_k_r == idx_r);
        if (issue_ctl.last) begin
          state_nxt = sia_pkg::ST_DRAIN;
        end else begin
          rd_k_nxt = rd_k_r + 1'b1;
        end
      end
      sia_pkg::ST_DRAIN: begin
      end
      default: begin
        state_nxt = sia_pkg::ST_IDLE;
      end
    endcase
    if (hit_ctl.vld) begin
      row_nxt   = row_r | row_set;
      res_k_nxt = res_k_r + 1'b1;
      if (hit_ctl.last) begin
        out_valid_nxt      = 1'b1;
        out_wire_index_nxt = idx_r;
        out_row_bits_nxt   = row_r | row_set;
        out_overflow_nxt   = 1'b0;
        state_nxt          = sia_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sia_pkg::ST_IDLE;
      count_r     <= '0;
      ctl0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ctl0_r      <= issue_ctl;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r            <= idx_nxt;
    rd_k_r           <= rd_k_nxt;
    res_k_r          <= res_k_nxt;
    seg_r            <= seg_nxt;
    row_r            <= row_nxt;
    out_wire_index_r <= out_wire_index_nxt;
    out_row_bits_r   <= out_row_bits_nxt;
    out_overflow_r   <= out_overflow_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_wire_index = out_wire_index_r;
  assign out_row_bits   = out_row_bits_r;
  assign out_overflow   = out_overflow_r;

endmodule

// File: sv/sia_checker.sv
module sia_checker #(
  parameter int MAX_WIRES = 64
) (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     start,
  input logic                                     busy,
  input logic                                     in_req_type,
  input logic                                     out_valid,
  input logic [((MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1)-1:0] out_wire_index,
  input logic [MAX_WIRES-1:0]                     out_row_bits,
  input logic                                     out_overflow
);

  // clear transfers give no result
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req_type) |=> !out_valid)
    else $error("result after clear transfer");

  // add transfer either starts a sweep or reports overflow at once
  a_add_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type) |=> (busy || (out_valid && out_overflow)))
    else $error("add transfer neither swept nor overflowed");

  a_diag_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow) |-> out_row_bits[out_wire_index])
    else $error("own bit missing in row");

  a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> ((out_row_bits == '0) && (out_wire_index == '0)))
    else $error("overflow result not empty");

  a_row_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow) |-> $past(busy))
    else $error("row result without sweep");

endmodule

bind segment_intersection_adjacency_core sia_checker #(.MAX_WIRES(MAX_WIRES)) u_sia_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_wire_index (out_wire_index),
  .out_row_bits   (out_row_bits),
  .out_overflow   (out_overflow)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_WIRES  = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = 6;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_ADD   = 1'b1;

  localparam int TURN_COLLINEAR = 0;
  localparam int TURN_CW        = 1;
  localparam int TURN_CCW       = 2;

  localparam logic [COORD_BITS-1:0] C_MAX = 16'hFFFF;

  typedef struct {
    longint ax;
    longint ay;
    longint bx;
    longint by;
  } wire_seg_t;

  typedef struct {
    logic [IDX_W-1:0]     idx;
    logic [MAX_WIRES-1:0] row;
    logic                 ovf;
  } adj_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_req_type;
  logic [COORD_BITS-1:0] in_start_x;
  logic [COORD_BITS-1:0] in_start_y;
  logic [COORD_BITS-1:0] in_end_x;
  logic [COORD_BITS-1:0] in_end_y;
  logic                  out_valid;
  logic [IDX_W-1:0]      out_wire_index;
  logic [MAX_WIRES-1:0]  out_row_bits;
  logic                  out_overflow;

  wire_seg_t   seg_mem [MAX_WIRES];
  int unsigned wire_total;
  adj_row_t    expected_rows [$];
  int          mismatches;
  bit          idle_en;

  segment_intersection_adjacency_core #(
    .MAX_WIRES  (MAX_WIRES),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_wire_index (out_wire_index),
    .out_row_bits   (out_row_bits),
    .out_overflow   (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int turn_of(longint px, py, qx, qy, rx, ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return TURN_COLLINEAR;
    return (v > 0) ? TURN_CW : TURN_CCW;
  endfunction

  // q inside the bounding box of p and r
  function automatic bit in_box(longint px, py, qx, qy, rx, ry);
    return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
           qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
  endfunction

  function automatic bit segs_meet(wire_seg_t s, wire_seg_t t);
    int o1, o2, o3, o4;
    o1 = turn_of(s.ax, s.ay, s.bx, s.by, t.ax, t.ay);
    o2 = turn_of(s.ax, s.ay, s.bx, s.by, t.bx, t.by);
    o3 = turn_of(t.ax, t.ay, t.bx, t.by, s.ax, s.ay);
    o4 = turn_of(t.ax, t.ay, t.bx, t.by, s.bx, s.by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == TURN_COLLINEAR && in_box(s.ax, s.ay, t.ax, t.ay, s.bx, s.by)) return 1'b1;
    if (o2 == TURN_COLLINEAR && in_box(s.ax, s.ay, t.bx, t.by, s.bx, s.by)) return 1'b1;
    if (o3 == TURN_COLLINEAR && in_box(t.ax, t.ay, s.ax, s.ay, t.bx, t.by)) return 1'b1;
    if (o4 == TURN_COLLINEAR && in_box(t.ax, t.ay, s.bx, s.by, t.bx, t.by)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_adjacency(logic rtype, logic [COORD_BITS-1:0] sx, sy,
                                            logic [COORD_BITS-1:0] ex, ey);
    wire_seg_t s;
    adj_row_t  r;
    if (rtype == REQ_CLEAR) begin
      wire_total = 0;
      return;
    end
    if (wire_total >= MAX_WIRES) begin
      r.idx = '0;
      r.row = '0;
      r.ovf = 1'b1;
      expected_rows.push_back(r);
      return;
    end
    s.ax = longint'(sx);
    s.ay = longint'(sy);
    s.bx = longint'(ex);
    s.by = longint'(ey);
    seg_mem[wire_total] = s;
    r.row = '0;
    for (int k = 0; k <= int'(wire_total); k++)
      if (segs_meet(s, seg_mem[k])) r.row[k] = 1'b1;
    r.idx = wire_total[IDX_W-1:0];
    r.ovf = 1'b0;
    expected_rows.push_back(r);
    wire_total++;
  endfunction

  always @(posedge clk) begin
    adj_row_t want;
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d row %h ovf %b",
                   out_wire_index, out_row_bits, out_overflow);
      end else begin
        want = expected_rows.pop_front();
        if (out_wire_index !== want.idx || out_row_bits !== want.row ||
            out_overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx %0d row %h ovf %b, got idx %0d row %h ovf %b",
                     want.idx, want.row, want.ovf,
                     out_wire_index, out_row_bits, out_overflow);
        end
      end
    end
  end

  // start stays high after a transfer so back-to-back requests need no extra NBA
  task automatic send_request(input logic rtype, input logic [COORD_BITS-1:0] sx, sy,
                              input logic [COORD_BITS-1:0] ex, ey);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(99) < 16)
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= rtype;
    in_start_x  <= sx;
    in_start_y  <= sy;
    in_end_x    <= ex;
    in_end_y    <= ey;
    do @(posedge clk); while (busy !== 1'b0);
    predict_adjacency(rtype, sx, sy, ex, ey);
  endtask

  task automatic wait_idle(input int settle);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
    case (mode)
      0:       return COORD_BITS'($urandom_range(0, 31));
      1:       return ($urandom_range(0, 16) == 16) ? C_MAX :
                      COORD_BITS'($urandom_range(0, 15) * 4096);
      2:       return $urandom_range(0, 1) ? C_MAX : '0;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_random_add();
    int mode, pick;
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    pick = $urandom_range(99);
    mode = (pick < 40) ? 0 : (pick < 65) ? 1 : (pick < 75) ? 2 : 3;
    sx = rand_coord(mode);
    sy = rand_coord(mode);
    if ($urandom_range(9) == 0) begin
      ex = sx;
      ey = sy;
    end else begin
      ex = rand_coord(mode);
      ey = rand_coord(mode);
    end
    send_request(REQ_ADD, sx, sy, ex, ey);
  endtask

  task automatic test_directed_geometry();
    idle_en = 1'b0;
    send_request(REQ_CLEAR, C_MAX, C_MAX, C_MAX, C_MAX);
    send_request(REQ_ADD, 16'h0000, 16'h0000, C_MAX, C_MAX);
    send_request(REQ_ADD, 16'h0000, C_MAX, C_MAX, 16'h0000);
    // points: on the main diagonal, then on the anti-diagonal
    send_request(REQ_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(REQ_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_request(REQ_ADD, 16'd1000, 16'd1000, 16'd2000, 16'd2000);
    send_request(REQ_ADD, 16'd0, 16'd10, 16'd10, 16'd20);
    send_request(REQ_ADD, 16'd20, 16'd30, 16'd30, 16'd40);
    send_request(REQ_ADD, 16'd0, 16'd100, 16'd100, 16'd100);
    send_request(REQ_ADD, 16'd0, 16'd101, 16'd100, 16'd101);
    send_request(REQ_ADD, 16'd100, 16'd100, 16'd200, 16'd50);
    send_request(REQ_ADD, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    send_request(REQ_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(REQ_ADD, C_MAX, C_MAX, C_MAX, C_MAX);
    send_request(REQ_ADD, C_MAX, 16'h0000, C_MAX, C_MAX);
    send_request(REQ_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_request(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(REQ_ADD, 16'd5, 16'd5, 16'd5, 16'd9);
    send_request(REQ_ADD, 16'd5, 16'd7, 16'd5, 16'd7);
  endtask

  task automatic test_store_overflow();
    idle_en = 1'b1;
    send_request(REQ_CLEAR, rand_coord(3), rand_coord(3), rand_coord(3), rand_coord(3));
    repeat (MAX_WIRES) send_random_add();
    repeat (3) send_random_add();
    send_request(REQ_CLEAR, rand_coord(3), rand_coord(3), rand_coord(3), rand_coord(3));
    send_random_add();
  endtask

  task automatic test_random_network();
    for (int n = 0; n < 460; n++) begin
      idle_en = !(n >= 200 && n < 350);
      if ($urandom_range(49) == 0)
        send_request(REQ_CLEAR, rand_coord(3), rand_coord(3), rand_coord(3),
                     rand_coord(3));
      else
        send_random_add();
    end
  endtask

  initial begin
    mismatches  = 0;
    wire_total  = 0;
    idle_en     = 1'b0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req_type <= REQ_CLEAR;
    in_start_x  <= '0;
    in_start_y  <= '0;
    in_end_x    <= '0;
    in_end_y    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_geometry();
    wait_idle(4);
    test_store_overflow();
    wait_idle(4);
    test_random_network();
    wait_idle(80);

    if (expected_rows.size() != 0) begin
      $display("%0d results never arrived", expected_rows.size());
      mismatches += expected_rows.size();
    end
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
